@@ design/job_shop_schedule_timer_macros.svh @@
// assertion macros shared by the job-shop schedule timer modules
`ifndef JOB_SHOP_SCHEDULE_TIMER_MACROS_SVH
`define JOB_SHOP_SCHEDULE_TIMER_MACROS_SVH

// same-cycle implication on clk, off during reset
`define JSST_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication on clk, off during reset
`define JSST_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/jsst_pkg.sv @@
// shared types, widths and helpers of the job-shop schedule timer
package jsst_pkg;

	localparam int TIME_W      = 32;
	localparam int LOT_W       = 6;
	localparam int STEP_W      = 4;
	localparam int MACH_W      = 4;
	localparam int MACHINES    = 1 << MACH_W;
	localparam int SLOT_W      = LOT_W + STEP_W;
	localparam int EPOCH_W     = 8;
	localparam int IN_FIELDS_W = LOT_W + STEP_W + MACH_W + TIME_W;
	localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = 3 * TIME_W;

	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
	localparam logic [EPOCH_W-1:0] EPOCH_MAX   = '1;
	localparam logic [TIME_W-1:0]  WAIT_RESET  = TIME_W'(1280);

	typedef struct packed {
		logic                new_sched;
		logic [LOT_W-1:0]    lot_id;
		logic [STEP_W-1:0]   step_index;
		logic [MACH_W-1:0]   machine_id;
		logic [TIME_W-1:0]   proc_time;
	} item_t;

	typedef struct packed {
		logic [TIME_W-1:0] start_time;
		logic [TIME_W-1:0] end_time;
		logic [TIME_W-1:0] makespan;
	} res_t;

	typedef struct packed {
		logic              en;
		logic              new_sched;
		logic [SLOT_W-1:0] addr;
	} rd_req_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
		logic [TIME_W-1:0] end_time;
	} wr_req_t;

	typedef struct packed {
		logic busy;
		logic full;
	} st_stat_t;

	typedef struct packed {
		logic [EPOCH_W-1:0] epoch;
		logic [TIME_W-1:0]  end_time;
	} st_word_t;

	function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
			input logic [TIME_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_W] ? '1 : s[TIME_W-1:0];
	endfunction

endpackage

@@ design/jsst_step_store.sv @@
// lot-step end time memory with epoch marks, forwarding and clearing pass
`include "job_shop_schedule_timer_macros.svh"

module jsst_step_store import jsst_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  rd_req_t           rd,
	input  wr_req_t           wr,
	input  logic              clr_start,
	output st_stat_t          stat,
	output logic              prev_hit,
	output logic [TIME_W-1:0] prev_time
);

	st_word_t           mem [1 << SLOT_W];
	st_word_t           rd_word_s1;
	logic [EPOCH_W-1:0] ep_q;
	logic [EPOCH_W-1:0] ep_s1;
	logic               clr_q;
	logic [SLOT_W-1:0]  clr_cnt_q;
	logic               fwd_s1;
	logic [TIME_W-1:0]  fwd_time_q;
	logic               mem_we;
	logic [SLOT_W-1:0]  mem_wa;
	st_word_t           mem_wd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
			ep_q      <= EPOCH_FIRST;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + SLOT_W'(1);
			if (&clr_cnt_q) begin
				clr_q <= 1'b0;
				ep_q  <= EPOCH_FIRST;
			end
		end else if (clr_start) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (rd.en && rd.new_sched) begin
			ep_q <= ep_q + EPOCH_W'(1);
		end
	end

	always_comb begin
		mem_we = clr_q || wr.en;
		mem_wa = clr_q ? clr_cnt_q : wr.addr;
		mem_wd = clr_q ? st_word_t'('0) : {ep_s1, wr.end_time};
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (rd.en) begin
			rd_word_s1 <= mem[rd.addr];
		end
	end

	// a write in the cycle of the read is not yet visible in the array
	always_ff @(posedge clk) begin
		if (rd.en) begin
			ep_s1  <= rd.new_sched ? ep_q + EPOCH_W'(1) : ep_q;
			fwd_s1 <= wr.en && (wr.addr == rd.addr) && !rd.new_sched;
		end
		if (wr.en) begin
			fwd_time_q <= wr.end_time;
		end
	end

	assign prev_hit  = fwd_s1 || (rd_word_s1.epoch == ep_s1);
	assign prev_time = fwd_s1 ? fwd_time_q : rd_word_s1.end_time;
	assign stat.busy = clr_q;
	assign stat.full = (ep_q == EPOCH_MAX);

	`JSST_ASSERT_IMP(a_no_wr_in_clr, clr_q, !wr.en, "step store written during clearing pass")
	`JSST_ASSERT_IMP(a_no_ep_wrap, rd.en && rd.new_sched, ep_q != EPOCH_MAX,
		"epoch advanced past its last value")

endmodule

@@ design/jsst_timing.sv @@
// machine table, makespan and start/end time evaluation of one operation
`include "job_shop_schedule_timer_macros.svh"

module jsst_timing import jsst_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  item_t             item,
	input  logic              fire,
	input  logic [TIME_W-1:0] wait_time,
	input  logic              prev_hit,
	input  logic [TIME_W-1:0] prev_time,
	output res_t              res
);

	logic [MACHINES-1:0] used_q;
	logic [TIME_W-1:0]   free_q [MACHINES];
	logic [TIME_W-1:0]   ms_q;
	logic                used;
	logic [TIME_W-1:0]   free;
	logic [TIME_W-1:0]   free_w;
	logic [TIME_W-1:0]   ready;
	logic [TIME_W-1:0]   start;
	logic [TIME_W-1:0]   stop;
	logic [TIME_W-1:0]   ms_base;
	logic [MACHINES-1:0] used_base;

	always_comb begin
		used_base = item.new_sched ? '0 : used_q;
		used      = used_base[item.machine_id];
		free      = free_q[item.machine_id];
		free_w    = sat_add(free, wait_time);
		ready     = prev_hit ? sat_add(prev_time, wait_time) : '0;
		if (item.step_index == '0) begin
			start = used ? free_w : '0;
		end else if (!used || (ready > free)) begin
			start = ready;
		end else begin
			start = free_w;
		end
		stop    = sat_add(start, item.proc_time);
		ms_base = item.new_sched ? '0 : ms_q;
		res.start_time = start;
		res.end_time   = stop;
		res.makespan   = (stop > ms_base) ? stop : ms_base;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			ms_q   <= '0;
		end else if (fire) begin
			used_q <= used_base | (MACHINES'(1) << item.machine_id);
			ms_q   <= res.makespan;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			free_q[item.machine_id] <= stop;
		end
	end

	`JSST_ASSERT_NXT(a_ms_mono, fire && !item.new_sched, ms_q >= $past(ms_q),
		"makespan fell within a schedule")

endmodule

@@ design/job_shop_schedule_timer.sv @@
// top level of the job-shop schedule timer: stream ports, stage and result registers
// One operation is taken per clock while the output is not stalled and no
// clearing pass runs. The beat is registered together with the read of the
// lot-step memory, its start, end and makespan are evaluated in that stage and
// written to the output register, which decouples the two sides. The 1024-entry
// lot-step memory is marked with an 8-bit schedule epoch, so a new schedule
// costs no time; after reset, and when a new-schedule beat arrives while the
// epoch is at its last value (every 254 new schedules), the input holds off while
// a clearing pass walks the memory. Configuration writes are taken at any time.
`include "job_shop_schedule_timer_macros.svh"

module job_shop_schedule_timer import jsst_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [TIME_W-1:0]      cfg_wr_data,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // lot_id, step_index, machine_id, proc_time
	input  logic                   s_tuser,   // new_schedule
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata    // start_time, end_time, makespan
);

	logic [TIME_W-1:0]      wait_q;
	logic                   s1_valid_q;
	item_t                  item_s1;
	item_t                  in_item;
	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;
	logic                   out_free;
	logic                   fire;
	logic                   adv;
	logic                   wrap_hold;
	logic                   acc;
	logic                   clr_start;
	rd_req_t                rd_req;
	wr_req_t                wr_req;
	st_stat_t               st_stat;
	logic                   prev_hit;
	logic [TIME_W-1:0]      prev_time;
	res_t                   res;

	always_comb begin
		in_item.new_sched  = s_tuser;
		in_item.lot_id     = s_tdata[LOT_W-1:0];
		in_item.step_index = s_tdata[LOT_W +: STEP_W];
		in_item.machine_id = s_tdata[LOT_W + STEP_W +: MACH_W];
		in_item.proc_time  = s_tdata[LOT_W + STEP_W + MACH_W +: TIME_W];
	end

	assign out_free  = !m_tvalid_q || m_tready;
	assign fire      = s1_valid_q && out_free;
	assign adv       = !s1_valid_q || out_free;
	assign wrap_hold = s_tvalid && s_tuser && st_stat.full;
	assign s_tready  = adv && !st_stat.busy && !wrap_hold;
	assign acc       = s_tvalid && s_tready;
	assign clr_start = wrap_hold && !s1_valid_q && !st_stat.busy;

	always_comb begin
		rd_req.en        = acc;
		rd_req.new_sched = s_tuser;
		rd_req.addr      = {in_item.lot_id, in_item.step_index - STEP_W'(1)};
		wr_req.en        = fire;
		wr_req.addr      = {item_s1.lot_id, item_s1.step_index};
		wr_req.end_time  = res.end_time;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_q     <= WAIT_RESET;
			s1_valid_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				wait_q <= cfg_wr_data;
			end
			if (adv) begin
				s1_valid_q <= acc;
			end
			if (out_free) begin
				m_tvalid_q <= s1_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			item_s1 <= in_item;
		end
		if (fire) begin
			m_tdata_q <= {res.makespan, res.end_time, res.start_time};
		end
	end

	jsst_step_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd        (rd_req),
		.wr        (wr_req),
		.clr_start (clr_start),
		.stat      (st_stat),
		.prev_hit  (prev_hit),
		.prev_time (prev_time)
	);

	jsst_timing u_timing (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_s1),
		.fire      (fire),
		.wait_time (wait_q),
		.prev_hit  (prev_hit),
		.prev_time (prev_time),
		.res       (res)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`JSST_ASSERT_IMP(a_rdy_gated, s_tready, !st_stat.busy && (!s1_valid_q || out_free),
		"input ready while stage blocked or clearing")
	`JSST_ASSERT_NXT(a_fire_out, fire, m_tvalid_q, "evaluated beat did not reach output")

endmodule
